FILE: rtl/encoder_tick_servo_drive_macros.svh
// Assertion macros used by the checker file of the servo drive.
`ifndef ENCODER_TICK_SERVO_DRIVE_MACROS_SVH
`define ENCODER_TICK_SERVO_DRIVE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ETSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ETSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/etsd_pkg.sv
// Package of the encoder tick servo drive: types, constants and helper functions.
`default_nettype none

package etsd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TURN,
        ST_DIST,
        ST_MUL_TURN,
        ST_MUL_STEER,
        ST_MUL_SPD,
        ST_WIDTH
    } state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANGLE_STEP      = 2'd0;
    localparam logic [1:0] CFG_DISTANCE_STEP   = 2'd1;
    localparam logic [1:0] CFG_STOP_WIDTH      = 2'd2;
    localparam logic [1:0] CFG_WIDTH_INCREMENT = 2'd3;

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_NEG2 = 2'b10;
    localparam logic [1:0] DIR_BACK = 2'b11;

    // Reset values
    localparam logic [11:0] RST_ANGLE_STEP      = 12'd1;
    localparam logic [11:0] RST_DISTANCE_STEP   = 12'd1;
    localparam logic [15:0] RST_STOP_WIDTH      = 16'd1500;
    localparam logic [7:0]  RST_WIDTH_INCREMENT = 8'd1;

    // Width law constants
    localparam logic [7:0]  TURN_GAIN  = 8'd50;
    localparam logic [39:0] TURN_BIAS  = 40'd7680;   // 60 * 128
    localparam logic [7:0]  FULL_SPEED = 8'd100;

    // Shared multiplier widths
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 8;
    localparam int MUL_P_W = 48;

    // Scale by a direction code (-2, -1, 0, 1)
    function automatic logic signed [49:0] dir_mul(input logic [1:0] dir,
                                                   input logic signed [49:0] x);
        case (dir)
            DIR_FWD:  return x;
            DIR_BACK: return -x;
            DIR_NEG2: return -(x <<< 1);
            default:  return '0;
        endcase
    endfunction

    function automatic logic [15:0] sat16(input logic signed [49:0] v);
        if (v < 50'sd0)
            return 16'h0000;
        else if (v > 50'sd65535)
            return 16'hFFFF;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/etsd_mul.sv
// Shared signed by unsigned multiplier with a registered product.
`default_nettype none

module etsd_mul (
    input  wire logic                                 clk,
    input  wire logic signed [etsd_pkg::MUL_A_W-1:0]  a,
    input  wire logic        [etsd_pkg::MUL_B_W-1:0]  b,
    output logic signed      [etsd_pkg::MUL_P_W-1:0]  prod_reg
);

    logic signed [etsd_pkg::MUL_A_W+etsd_pkg::MUL_B_W:0] full;
    logic signed [etsd_pkg::MUL_P_W-1:0]                  prod_next;

    assign full      = a * $signed({1'b0, b});
    assign prod_next = full[etsd_pkg::MUL_P_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

FILE: rtl/encoder_tick_servo_drive.sv
// Top level of the encoder tick servo drive: sequencer, tick remainders and width law.
//
//  channel | dir | beat fields
//  s_*     | in  | tuser: command_valid; tdata: ticks, direction, distance, turn, speed
//  m_*     | out | tdata: right_width, left_width, done_res, heading_out
//  cfg_*   | in  | write enable, register index, write data
//
// An input beat passes through idle, which takes it, a turn and then a distance step per
// encoder tick (through the shared saturating adder), three passes of the shared multiplier
// for the steering and speed terms, and a widths step that forms the widths.
// The result sits in an output register; the widths stage waits only if that is full.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none

module encoder_tick_servo_drive (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,   // [0] command_valid
    // [0] left_tick, [1] right_tick, [3:2] move_direction, [19:4] target_distance,
    // [35:20] target_turn, [43:36] target_speed, [47:44] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] right_width, [31:16] left_width, [32] done_res, [64:33] heading_out,
    // [71:65] zero
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    etsd_pkg::state_t state_reg, state_next;

    logic [11:0] angle_step_reg;
    logic [11:0] distance_step_reg;
    logic [15:0] stop_width_reg;
    logic [7:0]  width_inc_reg;

    logic signed [31:0] turn_reg, turn_next;
    logic signed [31:0] dist_reg, dist_next;
    logic [1:0]         dir_reg, dir_next;
    logic [7:0]         speed_reg, speed_next;
    logic [31:0]        heading_reg, heading_next;
    logic [15:0]        right_now_reg, right_now_next;
    logic [15:0]        left_now_reg, left_now_next;
    logic               side_reg, side_next;
    logic               left_pend_reg, left_pend_next;
    logic               right_pend_reg, right_pend_next;
    logic               done_reg, done_next;
    logic signed [47:0] steer_reg, steer_next;

    logic               m_valid_reg, m_valid_next;
    logic [15:0]        out_right_reg, out_right_next;
    logic [15:0]        out_left_reg, out_left_next;
    logic               out_done_reg, out_done_next;
    logic [31:0]        out_heading_reg, out_heading_next;

    logic signed [etsd_pkg::MUL_A_W-1:0] mul_a;
    logic        [etsd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [etsd_pkg::MUL_P_W-1:0] prod;

    // Input fields
    logic        in_cmd, in_left, in_right;
    logic [1:0]  in_dir;
    logic [15:0] in_dist, in_turn;
    logic [7:0]  in_speed;
    logic        accept, out_free;

    assign in_cmd   = s_tuser;
    assign in_left  = s_tdata[0];
    assign in_right = s_tdata[1];
    assign in_dir   = s_tdata[3:2];
    assign in_dist  = s_tdata[19:4];
    assign in_turn  = s_tdata[35:20];
    assign in_speed = s_tdata[43:36];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Tick arithmetic: one saturating adder shared by turn and distance
    logic [15:0]        wheel;
    logic               fwd, slow, in_turn_st;
    logic signed [32:0] turn_x, dist_x, ah, dh, add_a, add_step, add_sum;
    logic               add_sub, turn_band, dist_band;
    logic signed [31:0] add_sat;
    logic [31:0]        heading_step;

    assign wheel      = side_reg ? right_now_reg : left_now_reg;
    assign fwd        = wheel > stop_width_reg;
    assign slow       = wheel < stop_width_reg;
    assign in_turn_st = (state_reg == etsd_pkg::ST_TURN);
    assign turn_x     = {turn_reg[31], turn_reg};
    assign dist_x     = {dist_reg[31], dist_reg};
    assign ah         = $signed({22'd0, angle_step_reg[11:1]});
    assign dh         = $signed({22'd0, distance_step_reg[11:1]});
    assign turn_band  = (turn_x < ah) && (turn_x > -ah);
    assign dist_band  = (dist_x <= dh) && (dist_x >= -dh);
    assign add_a      = in_turn_st ? turn_x : dist_x;
    assign add_step   = in_turn_st ? $signed({21'd0, angle_step_reg})
                                   : $signed({21'd0, distance_step_reg});
    assign add_sub    = in_turn_st ? !fwd : (side_reg ? slow : fwd);
    assign add_sum    = add_sub ? (add_a - add_step) : (add_a + add_step);
    assign add_sat    = etsd_pkg::sat32(add_sum);
    assign heading_step = fwd ? (heading_reg + {20'd0, angle_step_reg})
                              : (heading_reg - {20'd0, angle_step_reg});

    // Width law
    logic [7:0]         spd_sel;
    logic               turn_pos, turn_neg;
    logic signed [49:0] stop50, dsi, steer_d, l_base, r_base, l_num, r_num;
    logic signed [49:0] inc128;
    logic [15:0]        r_val, l_val;

    assign spd_sel  = (dist_reg > 32'sd0) ? etsd_pkg::FULL_SPEED : speed_reg;
    assign turn_pos = !turn_reg[31] && (turn_reg != 32'sd0);
    assign turn_neg = turn_reg[31];
    assign stop50   = $signed({34'd0, stop_width_reg});
    assign inc128   = $signed({35'd0, width_inc_reg, 7'd0});
    assign dsi      = etsd_pkg::dir_mul(dir_reg, $signed({34'd0, prod[15:0]}));
    assign steer_d  = etsd_pkg::dir_mul(dir_reg, {{2{steer_reg[47]}}, steer_reg});
    assign l_base   = stop50 + dsi;
    assign r_base   = stop50 - dsi;
    // steering in 1/128 width, negative numerators saturate to zero anyway
    assign l_num    = (l_base <<< 7) - steer_d;
    assign r_num    = (r_base <<< 7) + steer_d;

    always_comb
    begin
        if (spd_sel != 8'd0)
        begin
            r_val = etsd_pkg::sat16(r_base);
            l_val = etsd_pkg::sat16(l_base);
            if (turn_pos)
                l_val = etsd_pkg::sat16(l_num >>> 7);
            else if (turn_neg)
                r_val = etsd_pkg::sat16(r_num >>> 7);
        end
        else if (turn_pos)
        begin
            r_val = etsd_pkg::sat16(stop50 - inc128);
            l_val = r_val;
        end
        else if (turn_neg)
        begin
            r_val = etsd_pkg::sat16(stop50 + inc128);
            l_val = r_val;
        end
        else
        begin
            r_val = stop_width_reg;
            l_val = stop_width_reg;
        end
    end

    etsd_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            etsd_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = (in_left || in_right) ? etsd_pkg::ST_TURN
                                                       : etsd_pkg::ST_MUL_TURN;
            etsd_pkg::ST_TURN:
                state_next = etsd_pkg::ST_DIST;
            etsd_pkg::ST_DIST:
                state_next = (!side_reg && right_pend_reg) ? etsd_pkg::ST_TURN
                                                           : etsd_pkg::ST_MUL_TURN;
            etsd_pkg::ST_MUL_TURN:
                state_next = etsd_pkg::ST_MUL_STEER;
            etsd_pkg::ST_MUL_STEER:
                state_next = etsd_pkg::ST_MUL_SPD;
            etsd_pkg::ST_MUL_SPD:
                state_next = etsd_pkg::ST_WIDTH;
            etsd_pkg::ST_WIDTH:
                if (out_free)
                    state_next = etsd_pkg::ST_IDLE;
            default:
                state_next = etsd_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier operands
    always_comb
    begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            etsd_pkg::ST_IDLE:
                s_tready = 1'b1;
            etsd_pkg::ST_MUL_TURN:
            begin
                mul_a = {{8{turn_reg[31]}}, turn_reg};
                mul_b = etsd_pkg::TURN_GAIN;
            end
            etsd_pkg::ST_MUL_STEER:
            begin
                mul_a = prod[etsd_pkg::MUL_A_W-1:0] + etsd_pkg::TURN_BIAS;
                mul_b = width_inc_reg;
            end
            // speed product held while the widths stage waits for the output register
            etsd_pkg::ST_MUL_SPD,
            etsd_pkg::ST_WIDTH:
            begin
                mul_a = $signed({32'd0, spd_sel});
                mul_b = width_inc_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        turn_next        = turn_reg;
        dist_next        = dist_reg;
        dir_next         = dir_reg;
        speed_next       = speed_reg;
        heading_next     = heading_reg;
        right_now_next   = right_now_reg;
        left_now_next    = left_now_reg;
        side_next        = side_reg;
        left_pend_next   = left_pend_reg;
        right_pend_next  = right_pend_reg;
        done_next        = done_reg;
        steer_next       = steer_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_right_next   = out_right_reg;
        out_left_next    = out_left_reg;
        out_done_next    = out_done_reg;
        out_heading_next = out_heading_reg;

        case (state_reg)
            etsd_pkg::ST_IDLE:
                if (accept)
                begin
                    if (in_cmd)
                    begin
                        dir_next   = in_dir;
                        dist_next  = {{16{in_dist[15]}}, in_dist};
                        turn_next  = {{16{in_turn[15]}}, in_turn};
                        speed_next = in_speed;
                    end
                    left_pend_next  = in_left;
                    right_pend_next = in_right;
                    side_next       = !in_left;
                    done_next       = 1'b0;
                end
            etsd_pkg::ST_TURN:
                if (turn_reg != 32'sd0)
                begin
                    if (turn_band)
                    begin
                        turn_next = '0;
                        if (dist_reg == 32'sd0)
                            done_next = 1'b1;
                    end
                    else
                    begin
                        turn_next    = add_sat;
                        heading_next = heading_step;
                    end
                end
            etsd_pkg::ST_DIST:
            begin
                if (dist_reg != 32'sd0)
                begin
                    if (dist_band)
                    begin
                        dist_next = '0;
                        if (turn_reg == 32'sd0)
                            done_next = 1'b1;
                    end
                    else
                        dist_next = add_sat;
                end
                if (!side_reg && right_pend_reg)
                    side_next = 1'b1;
            end
            etsd_pkg::ST_MUL_SPD:
                steer_next = prod;
            etsd_pkg::ST_WIDTH:
                if (out_free)
                begin
                    right_now_next   = r_val;
                    left_now_next    = l_val;
                    out_right_next   = r_val;
                    out_left_next    = l_val;
                    out_done_next    = done_reg;
                    out_heading_next = heading_reg;
                    m_valid_next     = 1'b1;
                end
            default:
            begin
                steer_next = steer_reg;
            end
        endcase
    end

    // Control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= etsd_pkg::ST_IDLE;
            turn_reg       <= '0;
            dist_reg       <= '0;
            dir_reg        <= etsd_pkg::DIR_NONE;
            speed_reg      <= '0;
            heading_reg    <= '0;
            right_now_reg  <= etsd_pkg::RST_STOP_WIDTH;
            left_now_reg   <= etsd_pkg::RST_STOP_WIDTH;
            side_reg       <= 1'b0;
            left_pend_reg  <= 1'b0;
            right_pend_reg <= 1'b0;
            done_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            turn_reg       <= turn_next;
            dist_reg       <= dist_next;
            dir_reg        <= dir_next;
            speed_reg      <= speed_next;
            heading_reg    <= heading_next;
            right_now_reg  <= right_now_next;
            left_now_reg   <= left_now_next;
            side_reg       <= side_next;
            left_pend_reg  <= left_pend_next;
            right_pend_reg <= right_pend_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_step_reg    <= etsd_pkg::RST_ANGLE_STEP;
            distance_step_reg <= etsd_pkg::RST_DISTANCE_STEP;
            stop_width_reg    <= etsd_pkg::RST_STOP_WIDTH;
            width_inc_reg     <= etsd_pkg::RST_WIDTH_INCREMENT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                etsd_pkg::CFG_ANGLE_STEP:      angle_step_reg    <= cfg_data[11:0];
                etsd_pkg::CFG_DISTANCE_STEP:   distance_step_reg <= cfg_data[11:0];
                etsd_pkg::CFG_STOP_WIDTH:      stop_width_reg    <= cfg_data;
                etsd_pkg::CFG_WIDTH_INCREMENT: width_inc_reg     <= cfg_data[7:0];
                default:                       width_inc_reg     <= width_inc_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        steer_reg       <= steer_next;
        out_right_reg   <= out_right_next;
        out_left_reg    <= out_left_next;
        out_done_reg    <= out_done_next;
        out_heading_reg <= out_heading_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_heading_reg, out_done_reg, out_left_reg, out_right_reg};

endmodule

`default_nettype wire

FILE: rtl/etsd_checker.sv
// Port-level checker of the servo drive and its bind to the top level.
`default_nettype none
`include "encoder_tick_servo_drive_macros.svh"

module etsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    `ETSD_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `ETSD_ASSERT(a_out_stable, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result beat changed while stalled")
    `ETSD_ASSERT(a_busy_after_in, clk, rst_n, s_tvalid && s_tready |=> !s_tready ##1 !s_tready, "input taken again before the item was worked")
    `ETSD_ASSERT(a_out_after_work, clk, rst_n, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without work in progress")
    `ETSD_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> !m_tvalid, "result valid straight after reset")

endmodule

bind encoder_tick_servo_drive etsd_checker u_etsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/encoder_tick_servo_drive_test.sv
// Self-checking testbench of the encoder tick servo drive, with its own model of the drive.
`timescale 1ns / 1ps

module encoder_tick_servo_drive_test;

    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     REPORT_CAP    = 60;
    localparam longint STEER_GAIN    = 50;
    localparam longint STEER_BIAS    = 60 * 128;
    localparam longint CRUISE_SPEED  = 100;
    localparam longint STEER_DIV     = 128;
    localparam longint REM_MAX       = 64'sd2147483647;
    localparam longint REM_MIN       = -64'sd2147483648;

    typedef struct {
        bit          cmd;
        bit          lt;
        bit          rt;
        logic [1:0]  dir;
        logic [15:0] distance;
        logic [15:0] turn;
        logic [7:0]  spd;
    } drive_event_t;

    typedef struct packed {
        logic [15:0] right_w;
        logic [15:0] left_w;
        logic        done;
        logic [31:0] heading;
    } servo_out_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // model copy of registers and drive state
    logic [11:0]        ang_step;
    logic [11:0]        dist_step;
    logic [15:0]        stop_w;
    logic [7:0]         w_inc;
    longint             turn_rem;
    longint             dist_rem;
    logic signed [1:0]  dir_held;
    logic [7:0]         spd_held;
    logic [31:0]        heading;
    logic [15:0]        right_now;
    logic [15:0]        left_now;

    servo_out_t servo_expect_q[$];

    bit gaps_on;
    int stall_request;
    int cycle_count;
    int error_count;
    int n_events;
    int n_results;
    int n_done;
    int n_settings;

    encoder_tick_servo_drive u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, servo_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > REM_MAX)
            return REM_MAX;
        if (v < REM_MIN)
            return REM_MIN;
        return v;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // one encoder tick on one wheel; returns 1 when a clear leaves both remainders at zero
    function automatic bit credit_tick(input logic [15:0] wheel, input bit is_left);
        longint a_st;
        longint d_st;
        longint a_half;
        longint d_half;
        bit     fwd;
        bit     sub;
        bit     fin;
        a_st   = ang_step;
        d_st   = dist_step;
        a_half = a_st >> 1;
        d_half = d_st >> 1;
        fwd    = wheel > stop_w;
        fin    = 1'b0;
        if (turn_rem != 0)
        begin
            if (turn_rem < a_half && turn_rem > -a_half)
            begin
                if (dist_rem == 0)
                    fin = 1'b1;
                turn_rem = 0;
            end
            else if (fwd)
            begin
                turn_rem = clamp32(turn_rem + a_st);
                heading  = heading + ang_step;
            end
            else
            begin
                turn_rem = clamp32(turn_rem - a_st);
                heading  = heading - ang_step;
            end
        end
        if (dist_rem != 0)
        begin
            if (dist_rem <= d_half && dist_rem >= -d_half)
            begin
                if (turn_rem == 0)
                    fin = 1'b1;
                dist_rem = 0;
            end
            else
            begin
                sub      = is_left ? fwd : (wheel < stop_w);
                dist_rem = clamp32(sub ? dist_rem - d_st : dist_rem + d_st);
            end
        end
        return fin;
    endfunction

    function automatic servo_out_t advance_drive(input drive_event_t ev);
        servo_out_t res;
        bit         fin;
        longint     stp;
        longint     inc;
        longint     d;
        longint     t;
        longint     sp;
        longint     steer;
        longint     r;
        longint     l;
        fin = 1'b0;
        if (ev.cmd)
        begin
            dir_held = ev.dir;
            dist_rem = $signed(ev.distance);
            turn_rem = $signed(ev.turn);
            spd_held = ev.spd;
        end
        if (ev.lt)
            fin = credit_tick(left_now, 1'b1) | fin;
        if (ev.rt)
            fin = credit_tick(right_now, 1'b0) | fin;

        stp = stop_w;
        inc = w_inc;
        d   = dir_held;
        t   = turn_rem;
        sp  = spd_held;
        if (dist_rem > 0)
            sp = CRUISE_SPEED;
        if (sp > 0)
        begin
            // steering term kept in 1/128 width units, truncated toward zero
            steer = d * (t * STEER_GAIN + STEER_BIAS) * inc;
            r = stp - d * sp * inc;
            l = stp + d * sp * inc;
            if (t > 0)
                l = (l * STEER_DIV - steer) / STEER_DIV;
            else if (t < 0)
                r = (r * STEER_DIV + steer) / STEER_DIV;
        end
        else if (t > 0)
        begin
            r = stp - 128 * inc;
            l = r;
        end
        else if (t < 0)
        begin
            r = stp + 128 * inc;
            l = r;
        end
        else
        begin
            r = stp;
            l = stp;
        end
        right_now   = clip16(r);
        left_now    = clip16(l);
        res.right_w = right_now;
        res.left_w  = left_now;
        res.done    = fin;
        res.heading = heading;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_dir();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return etsd_pkg::DIR_FWD;
        if (r < 7)
            return etsd_pkg::DIR_BACK;
        if (r < 9)
            return etsd_pkg::DIR_NONE;
        return etsd_pkg::DIR_NEG2;
    endfunction

    // targets mostly a few steps from zero so that sequences can run to completion
    function automatic logic [15:0] pick_target(input logic [11:0] step);
        int s;
        int v;
        int r;
        s = step;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r < 3)
            return 16'($urandom);
        v = $urandom_range(0, 4) * s + $urandom_range(0, s);
        if ($urandom_range(0, 1))
            v = -v;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // receiver: random stalls, plus a long hold-off when one is requested
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_request > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        servo_out_t want;
        servo_out_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.right_w = m_tdata[15:0];
            got.left_w  = m_tdata[31:16];
            got.done    = m_tdata[32];
            got.heading = m_tdata[64:33];
            n_results++;
            if (got.done)
                n_done++;
            if (servo_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
            end
            else
            begin
                want = servo_expect_q.pop_front();
                if (want !== got)
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display({"%0t: expected right %0d left %0d done %0b heading %0d,",
                                  " got right %0d left %0d done %0b heading %0d"},
                                 $time, want.right_w, want.left_w, want.done,
                                 $signed(want.heading), got.right_w, got.left_w, got.done,
                                 $signed(got.heading));
                end
            end
        end
    end

    task automatic send_event(input drive_event_t ev);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.cmd;
        s_tdata  <= {4'b0000, ev.spd, ev.turn, ev.distance, ev.dir, ev.rt, ev.lt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        servo_expect_q.push_back(advance_drive(ev));
        n_events++;
    endtask

    task automatic send_cmd(input bit lt, input bit rt, input logic [1:0] dir,
                            input int distance, input int turn, input int spd);
        drive_event_t ev;
        ev.cmd      = 1'b1;
        ev.lt       = lt;
        ev.rt       = rt;
        ev.dir      = dir;
        ev.distance = distance[15:0];
        ev.turn     = turn[15:0];
        ev.spd      = spd[7:0];
        send_event(ev);
    endtask

    task automatic settle_drive();
        s_tvalid <= 1'b0;
        while (servo_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            etsd_pkg::CFG_ANGLE_STEP:      ang_step  = val[11:0];
            etsd_pkg::CFG_DISTANCE_STEP:   dist_step = val[11:0];
            etsd_pkg::CFG_STOP_WIDTH:      stop_w    = val;
            etsd_pkg::CFG_WIDTH_INCREMENT: w_inc     = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input int a, input int d, input int s, input int i);
        write_reg(etsd_pkg::CFG_ANGLE_STEP, a[15:0]);
        write_reg(etsd_pkg::CFG_DISTANCE_STEP, d[15:0]);
        write_reg(etsd_pkg::CFG_STOP_WIDTH, s[15:0]);
        write_reg(etsd_pkg::CFG_WIDTH_INCREMENT, i[15:0]);
        n_settings++;
    endtask

    task automatic test_power_up_state();
        drive_event_t ev;
        ev = '{cmd: 1'b0, lt: 1'b0, rt: 1'b0, dir: etsd_pkg::DIR_NONE, distance: '0,
               turn: '0, spd: '0};
        send_event(ev);
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_FWD, 3, 0, 20);
        settle_drive();
    endtask

    task automatic test_extremes();
        drive_event_t ev;
        apply_settings(100, 100, 1500, 2);
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_FWD, 32767, 32767, 255);
        send_cmd(1'b1, 1'b0, etsd_pkg::DIR_BACK, -32768, -32768, 0);
        send_cmd(1'b0, 1'b1, etsd_pkg::DIR_NEG2, 1000, -500, 200);
        // turn inside half a step clears, distance already zero: done
        send_cmd(1'b1, 1'b0, etsd_pkg::DIR_FWD, 0, 30, 10);
        // distance on the half step boundary clears
        send_cmd(1'b0, 1'b1, etsd_pkg::DIR_NONE, 50, 0, 0);
        // turn on the boundary is stepped, not cleared
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_FWD, 0, -50, 5);
        send_cmd(1'b1, 1'b0, etsd_pkg::DIR_BACK, -50, 0, 0);
        // zero speed: turn sign alone sets both widths
        send_cmd(1'b0, 1'b0, etsd_pkg::DIR_NONE, 0, 700, 0);
        send_cmd(1'b0, 1'b0, etsd_pkg::DIR_NONE, 0, -700, 0);
        send_cmd(1'b0, 1'b0, etsd_pkg::DIR_NONE, 0, 0, 0);
        settle_drive();

        apply_settings(100, 100, 65535, 255);
        send_cmd(1'b0, 1'b0, etsd_pkg::DIR_FWD, 0, 0, 255);
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_BACK, 0, 32767, 255);
        settle_drive();

        apply_settings(100, 100, 0, 255);
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_FWD, -100, -32768, 255);
        send_cmd(1'b0, 1'b0, etsd_pkg::DIR_NONE, 0, 10, 0);
        settle_drive();

        // zero steps: ticks move nothing
        apply_settings(0, 0, 1500, 1);
        send_cmd(1'b1, 1'b1, etsd_pkg::DIR_FWD, 500, 500, 9);
        ev = '{cmd: 1'b0, lt: 1'b1, rt: 1'b1, dir: etsd_pkg::DIR_BACK, distance: 16'hFFFF,
               turn: 16'hFFFF, spd: 8'hFF};
        send_event(ev);
        settle_drive();
    endtask

    task automatic run_random_phase(input int n_items);
        drive_event_t ev;
        int sent;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                ev.cmd      = 1'b1;
                ev.lt       = 1'($urandom_range(0, 1));
                ev.rt       = 1'($urandom_range(0, 1));
                ev.dir      = pick_dir();
                ev.distance = pick_target(dist_step);
                ev.turn     = pick_target(ang_step);
                ev.spd      = 8'($urandom_range(0, 255));
                send_event(ev);
                sent++;
                k = $urandom_range(1, 14);
                repeat (k)
                begin
                    ev.cmd      = 1'b0;
                    ev.lt       = 1'($urandom_range(0, 1));
                    ev.rt       = 1'($urandom_range(0, 1));
                    if (!ev.lt && !ev.rt && $urandom_range(0, 3) != 0)
                        ev.rt = 1'b1;
                    ev.dir      = 2'($urandom_range(0, 3));
                    ev.distance = 16'($urandom);
                    ev.turn     = 16'($urandom);
                    ev.spd      = 8'($urandom_range(0, 255));
                    send_event(ev);
                    sent++;
                end
            end
            else
            begin
                ev.cmd      = 1'($urandom_range(0, 1));
                ev.lt       = 1'($urandom_range(0, 1));
                ev.rt       = 1'($urandom_range(0, 1));
                ev.dir      = 2'($urandom_range(0, 3));
                ev.distance = 16'($urandom);
                ev.turn     = 16'($urandom);
                ev.spd      = 8'($urandom_range(0, 255));
                send_event(ev);
                sent++;
            end
        end
        settle_drive();
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_output_stall();
        gaps_on = 1'b0;
        apply_settings(25, 40, 1500, 3);
        stall_request = 400;
        run_random_phase(40);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(1, 1, 1500, 1);
                1: apply_settings(4095, 4095, 65535, 255);
                2: apply_settings(4095, 1, 0, 255);
                3: apply_settings(7, 13, 1500, 3);
                4: apply_settings(1, 4095, 32768, 0);
                default: apply_settings($urandom_range(1, 4095), $urandom_range(1, 4095),
                                        $urandom_range(0, 65535), $urandom_range(0, 255));
            endcase
            gaps_on = (p != 2);
            run_random_phase(265);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_index     = etsd_pkg::CFG_ANGLE_STEP;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        stall_request = 0;
        cycle_count   = 0;
        error_count   = 0;
        n_events      = 0;
        n_results     = 0;
        n_done        = 0;
        n_settings    = 0;
        ang_step      = etsd_pkg::RST_ANGLE_STEP;
        dist_step     = etsd_pkg::RST_DISTANCE_STEP;
        stop_w        = etsd_pkg::RST_STOP_WIDTH;
        w_inc         = etsd_pkg::RST_WIDTH_INCREMENT;
        turn_rem      = 0;
        dist_rem      = 0;
        dir_held      = '0;
        spd_held      = '0;
        heading       = '0;
        right_now     = etsd_pkg::RST_STOP_WIDTH;
        left_now      = etsd_pkg::RST_STOP_WIDTH;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_state();
        test_extremes();
        test_output_stall();
        test_random_settings();
        settle_drive();

        $display("run covered %0d events over %0d register settings, incl. a long output stall",
                 n_events, n_settings);
        $display("%0d results checked, %0d marked a finished movement, %0d errors",
                 n_results, n_done, error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
